[rtl/tpsg_pkg.sv]
// Shared types, latencies and saturating helpers for the two-phase flux block.
`timescale 1ns / 1ps
package tpsg_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_GAMMA_ONE = 2'd0;
  localparam logic [1:0] REG_PI_ONE    = 2'd1;
  localparam logic [1:0] REG_GAMMA_TWO = 2'd2;
  localparam logic [1:0] REG_PI_TWO    = 2'd3;

  localparam logic [28:0] GAMMA_RST = 29'd23488102;

  // Pipeline depths
  localparam int MUL_LAT  = 3;
  localparam int DIV_LAT  = 66;
  localparam int LANE_LAT = DIV_LAT + 3 * MUL_LAT + 3;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Value with its saturation marker
  typedef struct packed {
    logic        sat;
    logic [63:0] v;
  } sval_t;

  // Signed result from sign and magnitude, clamped to 64 bits
  function automatic sval_t from_mag(input logic neg, input logic [63:0] m);
    sval_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (m[63]) begin
        r.v   = S64_MIN;
        r.sat = |m[62:0];
      end else begin
        r.v = 64'd0 - m;
      end
    end else begin
      if (m[63]) begin
        r.v   = S64_MAX;
        r.sat = 1'b1;
      end else begin
        r.v = m;
      end
    end
    return r;
  endfunction

  function automatic sval_t sat_add(input logic [63:0] a, input logic [63:0] b);
    sval_t       r;
    logic [63:0] s;
    s     = a + b;
    r.sat = (a[63] == b[63]) && (s[63] != a[63]);
    r.v   = r.sat ? (a[63] ? S64_MIN : S64_MAX) : s;
    return r;
  endfunction

  function automatic sval_t sat_sub(input logic [63:0] a, input logic [63:0] b);
    sval_t       r;
    logic [63:0] s;
    s     = a - b;
    r.sat = (a[63] != b[63]) && (s[63] != a[63]);
    r.v   = r.sat ? (a[63] ? S64_MIN : S64_MAX) : s;
    return r;
  endfunction

endpackage

[rtl/tpsg_dly.sv]
// Enabled shift-register delay line for pipeline side data.
`timescale 1ns / 1ps
module tpsg_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  // Shift on each pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

[rtl/tpsg_mul.sv]
// Three-stage 64x64 signed multiply, shift right, truncate toward zero, saturate.
`timescale 1ns / 1ps
module tpsg_mul #(
  parameter int SH = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        sat
);

  logic        neg1_r, neg2_r;
  logic [63:0] ma_r, mb_r;
  logic [63:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic [63:0] p_r;
  logic        sat_r;

  logic [127:0]        prod;
  logic                hi_nz;
  tpsg_pkg::sval_t     res;

  // Stage 1: magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      ma_r   <= a[63] ? 64'd0 - a : a;
      mb_r   <= b[63] ? 64'd0 - b : b;
    end
  end

  // Stage 2: 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r <= neg1_r;
      pp0_r  <= ma_r[31:0]  * mb_r[31:0];
      pp1_r  <= ma_r[31:0]  * mb_r[63:32];
      pp2_r  <= ma_r[63:32] * mb_r[31:0];
      pp3_r  <= ma_r[63:32] * mb_r[63:32];
    end
  end

  // Stage 3: sum, shift, clamp
  always_comb begin
    prod  = {pp3_r, 64'd0} + ({64'd0, pp1_r} << 32) + ({64'd0, pp2_r} << 32)
          + {64'd0, pp0_r};
    hi_nz = |(prod >> (SH + 64));
    res   = tpsg_pkg::from_mag(neg2_r, prod[SH+63:SH]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (hi_nz) begin
        p_r   <= neg2_r ? tpsg_pkg::S64_MIN : tpsg_pkg::S64_MAX;
        sat_r <= 1'b1;
      end else begin
        p_r   <= res.v;
        sat_r <= res.sat;
      end
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

[rtl/tpsg_div.sv]
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
`timescale 1ns / 1ps
module tpsg_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [62:0] den,
  output logic [63:0] quo,
  output logic        sat
);

  localparam int STEPS = 64;

  logic [62:0] rem_r  [STEPS+1];
  logic [63:0] lo_r   [STEPS+1];
  logic [63:0] q_r    [STEPS+1];
  logic [62:0] den_r  [STEPS+1];
  logic        neg_r  [STEPS+1];
  logic        zero_r [STEPS+1];
  logic        esat_r [STEPS+1];

  logic [63:0]  mm;
  logic [127:0] dvd;
  logic [63:0]  quo_r;
  logic         sat_r;
  tpsg_pkg::sval_t res;

  // Entry: magnitude, scaled dividend, early overflow check
  always_comb begin
    mm  = num[63] ? 64'd0 - num : num;
    dvd = {64'd0, mm} << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= dvd[126:64];
      lo_r[0]   <= dvd[63:0];
      q_r[0]    <= 64'd0;
      den_r[0]  <= den;
      neg_r[0]  <= num[63];
      zero_r[0] <= (den == 63'd0);
      esat_r[0] <= (dvd[127:64] >= {1'b0, den}) && (den != 63'd0);
    end
  end

  // One shift-compare-subtract per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [63:0] rem_s;
    logic        ge;
    assign rem_s = {rem_r[i], lo_r[i][63]};
    assign ge    = rem_s >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? 63'(rem_s - {1'b0, den_r[i]}) : rem_s[62:0];
        lo_r[i+1]   <= {lo_r[i][62:0], 1'b0};
        q_r[i+1]    <= {q_r[i][62:0], ge};
        den_r[i+1]  <= den_r[i];
        neg_r[i+1]  <= neg_r[i];
        zero_r[i+1] <= zero_r[i];
        esat_r[i+1] <= esat_r[i];
      end
    end
  end

  // Exit: sign, zero-density and overflow handling
  assign res = tpsg_pkg::from_mag(neg_r[STEPS], q_r[STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[STEPS]) begin
        quo_r <= 64'd0;
        sat_r <= 1'b0;
      end else if (esat_r[STEPS]) begin
        quo_r <= neg_r[STEPS] ? tpsg_pkg::S64_MIN : tpsg_pkg::S64_MAX;
        sat_r <= 1'b1;
      end else begin
        quo_r <= res.v;
        sat_r <= res.sat;
      end
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule

[rtl/tpsg_lane.sv]
// One phase: velocity, weighted pressure and the three Euler fluxes.
`timescale 1ns / 1ps
module tpsg_lane #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] alpha,
  input  logic [28:0] gamma,
  input  logic [61:0] pi,
  input  logic [62:0] density,
  input  logic [63:0] momentum,
  input  logic [63:0] energy,
  output logic [63:0] mass_flux,
  output logic [63:0] mom_flux,
  output logic [63:0] en_flux,
  output logic        zero,
  output logic        sat
);

  localparam int          M = tpsg_pkg::MUL_LAT;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  logic [63:0] u, m66, e66, e69, u74;
  logic        usat, usat69;
  logic [63:0] ag, pt;
  logic        ag_sat, ag_sat6, pt_sat;
  logic [64:0] pterm73;
  logic [63:0] half, mu, eu, mu77, eu77;
  logic        half_sat, mu_sat, eu_sat;
  logic [63:0] diff_r, ap_r, ap1, ap77, apu;
  logic        sat70_r, sat74_r, sat73, sat77, ap1_sat, apu_sat;
  logic [63:0] gm1;
  logic [63:0] mom_r, enf_r;
  logic        sat_r;
  tpsg_pkg::sval_t d_s, a_s, mom_s, en_s;

  assign gm1 = {35'd0, gamma} - ONE_Q;

  // Velocity
  tpsg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .num(momentum), .den(density), .quo(u), .sat(usat)
  );

  tpsg_dly #(.W(64), .N(tpsg_pkg::DIV_LAT)) u_m66 (.clk(clk), .en(en), .d(momentum), .q(m66));
  tpsg_dly #(.W(64), .N(tpsg_pkg::DIV_LAT)) u_e66 (.clk(clk), .en(en), .d(energy), .q(e66));
  tpsg_dly #(.W(1), .N(tpsg_pkg::LANE_LAT)) u_zero (
    .clk(clk), .en(en), .d(density == 63'd0), .q(zero)
  );

  // Stiffening term alpha*gamma*pi, computed alongside the division
  tpsg_mul #(.SH(FRAC_BITS)) u_ag (
    .clk(clk), .en(en), .a(alpha), .b({35'd0, gamma}), .p(ag), .sat(ag_sat)
  );
  tpsg_mul #(.SH(FRAC_BITS)) u_pt (
    .clk(clk), .en(en), .a(ag), .b({2'd0, pi}), .p(pt), .sat(pt_sat)
  );
  tpsg_dly #(.W(1), .N(M)) u_agsat (.clk(clk), .en(en), .d(ag_sat), .q(ag_sat6));
  tpsg_dly #(.W(65), .N(tpsg_pkg::DIV_LAT + 1)) u_pterm (
    .clk(clk), .en(en), .d({ag_sat6 | pt_sat, pt}), .q(pterm73)
  );

  // Products with the velocity
  tpsg_mul #(.SH(FRAC_BITS + 1)) u_half (
    .clk(clk), .en(en), .a(m66), .b(u), .p(half), .sat(half_sat)
  );
  tpsg_mul #(.SH(FRAC_BITS)) u_mu (
    .clk(clk), .en(en), .a(m66), .b(u), .p(mu), .sat(mu_sat)
  );
  tpsg_mul #(.SH(FRAC_BITS)) u_eu (
    .clk(clk), .en(en), .a(e66), .b(u), .p(eu), .sat(eu_sat)
  );
  tpsg_dly #(.W(64), .N(M)) u_e69 (.clk(clk), .en(en), .d(e66), .q(e69));
  tpsg_dly #(.W(1), .N(M)) u_us69 (.clk(clk), .en(en), .d(usat), .q(usat69));
  tpsg_dly #(.W(64), .N(2 * M + 2)) u_mu77 (.clk(clk), .en(en), .d(mu), .q(mu77));
  tpsg_dly #(.W(64), .N(2 * M + 2)) u_eu77 (.clk(clk), .en(en), .d(eu), .q(eu77));
  tpsg_dly #(.W(64), .N(2 * M + 2)) u_u74 (.clk(clk), .en(en), .d(u), .q(u74));

  // Internal energy part: E - m*u/2
  assign d_s = tpsg_pkg::sat_sub(e69, half);

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r  <= d_s.v;
      sat70_r <= usat69 | half_sat | mu_sat | eu_sat | d_s.sat;
    end
  end

  // Weighted pressure
  tpsg_mul #(.SH(FRAC_BITS)) u_ap1 (
    .clk(clk), .en(en), .a(gm1), .b(diff_r), .p(ap1), .sat(ap1_sat)
  );
  tpsg_dly #(.W(1), .N(M)) u_s73 (.clk(clk), .en(en), .d(sat70_r), .q(sat73));

  assign a_s = tpsg_pkg::sat_sub(ap1, pterm73[63:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      ap_r    <= a_s.v;
      sat74_r <= sat73 | ap1_sat | pterm73[64] | a_s.sat;
    end
  end

  tpsg_mul #(.SH(FRAC_BITS)) u_apu (
    .clk(clk), .en(en), .a(ap_r), .b(u74), .p(apu), .sat(apu_sat)
  );
  tpsg_dly #(.W(64), .N(M)) u_ap77 (.clk(clk), .en(en), .d(ap_r), .q(ap77));
  tpsg_dly #(.W(1), .N(M)) u_s77 (.clk(clk), .en(en), .d(sat74_r), .q(sat77));
  tpsg_dly #(.W(64), .N(3 * M + 3)) u_mass (.clk(clk), .en(en), .d(m66), .q(mass_flux));

  // Flux sums
  assign mom_s = tpsg_pkg::sat_add(mu77, ap77);
  assign en_s  = tpsg_pkg::sat_add(eu77, apu);

  always_ff @(posedge clk) begin
    if (en) begin
      mom_r <= mom_s.v;
      enf_r <= en_s.v;
      sat_r <= sat77 | apu_sat | mom_s.sat | en_s.sat;
    end
  end

  assign mom_flux = mom_r;
  assign en_flux  = enf_r;
  assign sat      = sat_r;

endmodule

[rtl/two_phase_stiffened_gas_flux.sv]
// Top level: config registers, two phase lanes, merge and output register.
//
// Two-phase stiffened-gas Euler flux, one cell per transfer.
// Input stream in_*: tdata carries the volume fraction and each phase's partial
// density, momentum and energy; tlast marks the last cell of a sweep.
// Output stream out_*: tdata carries the six fluxes, tuser the zero-density
// flags and the saturation flag, tlast follows the input marker.
// Config channel cfg_*: index 0..3 selects gamma_one, pi_one, gamma_two, pi_two;
// always ready; the user must write it only while the pipeline is empty, as the
// block does not enforce it. Throughput: one cell per cycle unless stalled.
// The pipeline is the 66-stage bit-per-stage velocity divider followed by three
// chained 3-stage multipliers and their add stages, then the output register.
// The whole pipeline advances together; when the output register is full and
// out_tready is low, the pipeline holds and in_tready drops.
// Reset (rst_n low, synchronous) empties the pipeline and restores gamma to 1.4
// and pi to zero.
`timescale 1ns / 1ps
module two_phase_stiffened_gas_flux #(
  parameter int FRAC_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // alpha_one, density_one, momentum_one, energy_one, density_two,
  // momentum_two, energy_two, one pad bit
  input  logic [407:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // mass_flux_one, momentum_flux_one, energy_flux_one,
  // mass_flux_two, momentum_flux_two, energy_flux_two
  output logic [383:0] out_tdata,
  // zero_density_flag[1:0], saturated_flag
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [61:0]  cfg_data
);

  localparam int          L     = tpsg_pkg::LANE_LAT;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  logic [28:0]  gamma_one_r, gamma_two_r;
  logic [61:0]  pi_one_r, pi_two_r;
  logic [L-1:0] vld_r;
  logic         en, last_d;
  logic [63:0]  a1, a2;
  logic [63:0]  mass1, mom1, en1, mass2, mom2, en2;
  logic         z1, z2, s1, s2;
  logic         out_valid_r, out_last_r;
  logic [383:0] out_data_r;
  logic [2:0]   out_user_r;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_one_r <= tpsg_pkg::GAMMA_RST;
      pi_one_r    <= 62'd0;
      gamma_two_r <= tpsg_pkg::GAMMA_RST;
      pi_two_r    <= 62'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpsg_pkg::REG_GAMMA_ONE: gamma_one_r <= cfg_data[28:0];
        tpsg_pkg::REG_PI_ONE:    pi_one_r    <= cfg_data;
        tpsg_pkg::REG_GAMMA_TWO: gamma_two_r <= cfg_data[28:0];
        tpsg_pkg::REG_PI_TWO:    pi_two_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Volume fractions, clamped to one
  always_comb begin
    a1 = {39'd0, in_tdata[24:0]};
    if (a1 > ONE_Q) begin
      a1 = ONE_Q;
    end
    a2 = ONE_Q - a1;
  end

  tpsg_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_one (
    .clk(clk), .en(en), .alpha(a1), .gamma(gamma_one_r), .pi(pi_one_r),
    .density(in_tdata[87:25]), .momentum(in_tdata[151:88]),
    .energy(in_tdata[215:152]),
    .mass_flux(mass1), .mom_flux(mom1), .en_flux(en1), .zero(z1), .sat(s1)
  );

  tpsg_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_two (
    .clk(clk), .en(en), .alpha(a2), .gamma(gamma_two_r), .pi(pi_two_r),
    .density(in_tdata[278:216]), .momentum(in_tdata[342:279]),
    .energy(in_tdata[406:343]),
    .mass_flux(mass2), .mom_flux(mom2), .en_flux(en2), .zero(z2), .sat(s2)
  );

  tpsg_dly #(.W(1), .N(L)) u_last (.clk(clk), .en(en), .d(in_tlast), .q(last_d));

  // Item valid tracking through the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end

  // Merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {en2, mom2, mass2, en1, mom1, mass1};
      out_user_r <= {s1 | s2, z2, z1};
      out_last_r <= last_d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

[verif/tb_two_phase_stiffened_gas_flux.sv]
// Testbench for the two-phase stiffened-gas flux block: stream driver, monitor, flux predictor.
`timescale 1ns / 1ps
module tb_two_phase_stiffened_gas_flux;

  localparam logic [63:0] Q_ONE     = 64'd1 << 24;
  localparam logic [63:0] POS_LIMIT = {1'b0, {63{1'b1}}};
  localparam logic [63:0] NEG_LIMIT = {1'b1, {63{1'b0}}};
  localparam int          CYCLE_CAP = 400000;
  localparam int          DRAIN_WAIT = 100;

  typedef struct {
    logic [24:0] alpha;
    logic [62:0] rho1;
    logic [63:0] mom1;
    logic [63:0] nrg1;
    logic [62:0] rho2;
    logic [63:0] mom2;
    logic [63:0] nrg2;
    logic        last;
  } cell_t;

  typedef struct {
    logic [63:0] flux [6];
    logic [1:0]  zero_rho;
    logic        sat;
    logic        last;
  } flux_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [407:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [383:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [61:0]  cfg_data;

  two_phase_stiffened_gas_flux uut (.*);

  // Shadow copy of the gas constants
  logic [28:0] gam1_q, gam2_q;
  logic [61:0] pi1_q, pi2_q;
  logic        sat_seen;

  cell_t  pending_cells [$];
  flux_t  flux_expected [$];
  cell_t  cur_cell;
  int     send_idle, recv_idle;
  int     errors;
  int     cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fixed point helpers, all saturating to the signed 64-bit range
  function automatic logic [63:0] magnitude(logic [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic [63:0] signed_of(logic neg, logic [63:0] m);
    if (neg) begin
      if (m[63]) begin
        if (|m[62:0]) sat_seen = 1'b1;
        return NEG_LIMIT;
      end
      return 64'd0 - m;
    end
    if (m[63]) begin
      sat_seen = 1'b1;
      return POS_LIMIT;
    end
    return m;
  endfunction

  function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b, int sh);
    logic         neg;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    if ((p >> (64 + sh)) != 0) begin
      sat_seen = 1'b1;
      return neg ? NEG_LIMIT : POS_LIMIT;
    end
    p = p >> sh;
    return signed_of(neg, p[63:0]);
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? NEG_LIMIT : POS_LIMIT;
    end
    return s;
  endfunction

  function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? NEG_LIMIT : POS_LIMIT;
    end
    return s;
  endfunction

  // Velocity m / rho in Q.24, truncated
  function automatic logic [63:0] velocity(logic [63:0] m, logic [62:0] rho);
    logic [63:0]  mm;
    logic [127:0] q;
    mm = magnitude(m);
    if ((mm >> 40) >= {1'b0, rho}) begin
      sat_seen = 1'b1;
      return m[63] ? NEG_LIMIT : POS_LIMIT;
    end
    q = ({64'd0, mm} << 24) / {65'd0, rho};
    return signed_of(m[63], q[63:0]);
  endfunction

  // One phase: returns 1 when its density is zero
  function automatic logic lane_flux(logic [63:0] alpha, logic [28:0] gam, logic [61:0] pi,
                                     logic [62:0] rho, logic [63:0] m, logic [63:0] e,
                                     output logic [63:0] f_mom, output logic [63:0] f_nrg);
    logic [63:0] g, u, half, ap;
    g = {35'd0, gam};
    u = 64'd0;
    if (rho != 0) u = velocity(m, rho);
    half = mul_q(m, u, 25);
    ap = sub_sat(mul_q(g - Q_ONE, sub_sat(e, half), 24),
                 mul_q(mul_q(alpha, g, 24), {2'd0, pi}, 24));
    f_mom = add_sat(mul_q(m, u, 24), ap);
    f_nrg = add_sat(mul_q(e, u, 24), mul_q(ap, u, 24));
    return rho == 0;
  endfunction

  function automatic flux_t cell_fluxes(cell_t c);
    flux_t       r;
    logic [63:0] a1;
    a1 = {39'd0, c.alpha};
    if (a1 > Q_ONE) a1 = Q_ONE;
    sat_seen = 1'b0;
    r.flux[0] = c.mom1;
    r.flux[3] = c.mom2;
    r.zero_rho[0] = lane_flux(a1, gam1_q, pi1_q, c.rho1, c.mom1, c.nrg1, r.flux[1], r.flux[2]);
    r.zero_rho[1] = lane_flux(Q_ONE - a1, gam2_q, pi2_q, c.rho2, c.mom2, c.nrg2,
                              r.flux[4], r.flux[5]);
    r.sat  = sat_seen;
    r.last = c.last;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) flux_expected.push_back(cell_fluxes(cur_cell));
      if (!in_tvalid || in_tready) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_cell = pending_cells.pop_front();
          in_tdata <= {1'b0, cur_cell.nrg2, cur_cell.mom2, cur_cell.rho2, cur_cell.nrg1,
                       cur_cell.mom1, cur_cell.rho1, cur_cell.alpha};
          in_tlast <= cur_cell.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    flux_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (flux_expected.size() == 0) begin
          report("unexpected transfer", out_tdata[63:0], 64'd0);
        end else begin
          want = flux_expected.pop_front();
          for (int k = 0; k < 6; k++)
            if (out_tdata[64*k +: 64] !== want.flux[k])
              report($sformatf("flux %0d", k), out_tdata[64*k +: 64], want.flux[k]);
          if (out_tuser[1:0] !== want.zero_rho)
            report("zero density flag", out_tuser[1:0], want.zero_rho);
          if (out_tuser[2] !== want.sat) report("saturation flag", out_tuser[2], want.sat);
          if (out_tlast !== want.last) report("tlast", out_tlast, want.last);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One register write, then cfg_valid drops and the channel idles before return
  task automatic write_reg(logic [1:0] idx, logic [61:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tpsg_pkg::REG_GAMMA_ONE: gam1_q = val[28:0];
      tpsg_pkg::REG_PI_ONE:    pi1_q = val;
      tpsg_pkg::REG_GAMMA_TWO: gam2_q = val[28:0];
      default:                 pi2_q = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Signed value of about the given bit count
  function automatic logic [63:0] rand_signed(int bits);
    logic [63:0] v;
    v = rand64() >> (64 - bits);
    return $urandom_range(1) ? 64'd0 - v : v;
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    if ($urandom_range(9) < 7) begin
      // physically shaped cell: moderate density, momentum and energy
      c.alpha = ($urandom_range(19) == 0) ? 25'($urandom) : 25'($urandom_range(0, 1 << 24));
      c.rho1 = ($urandom_range(24) == 0) ? 63'd0 : 63'(rand64() >> $urandom_range(24, 60));
      c.rho2 = ($urandom_range(24) == 0) ? 63'd0 : 63'(rand64() >> $urandom_range(24, 60));
      c.mom1 = rand_signed($urandom_range(8, 44));
      c.mom2 = rand_signed($urandom_range(8, 44));
      c.nrg1 = rand_signed($urandom_range(8, 50));
      c.nrg2 = rand_signed($urandom_range(8, 50));
    end else begin
      c.alpha = 25'($urandom);
      c.rho1 = 63'(rand64());
      c.rho2 = 63'(rand64());
      c.mom1 = rand64();
      c.mom2 = rand64();
      c.nrg1 = rand64();
      c.nrg2 = rand64();
    end
    c.last = ($urandom_range(15) == 0);
    return c;
  endfunction

  function automatic cell_t make_cell(logic [24:0] a, logic [62:0] r1, logic [63:0] m1,
                                      logic [63:0] e1, logic [62:0] r2, logic [63:0] m2,
                                      logic [63:0] e2, logic l);
    cell_t c;
    c.alpha = a; c.rho1 = r1; c.mom1 = m1; c.nrg1 = e1;
    c.rho2 = r2; c.mom2 = m2; c.nrg2 = e2; c.last = l;
    return c;
  endfunction

  initial begin
    logic [62:0] rmax;
    rmax = {63{1'b1}};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tpsg_pkg::REG_GAMMA_ONE;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    gam1_q = tpsg_pkg::GAMMA_RST;
    gam2_q = tpsg_pkg::GAMMA_RST;
    pi1_q = '0;
    pi2_q = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      // constants change only with the pipeline empty
      case (phase)
        0: begin
          write_reg(tpsg_pkg::REG_GAMMA_ONE, 62'd16777216);
          write_reg(tpsg_pkg::REG_PI_ONE, 62'd0);
          write_reg(tpsg_pkg::REG_GAMMA_TWO, 62'd268435456);
          write_reg(tpsg_pkg::REG_PI_TWO, {62{1'b1}});
          send_idle = 24; recv_idle = 74;
        end
        1: begin
          write_reg(tpsg_pkg::REG_GAMMA_ONE, 62'($urandom_range(16777216, 268435456)));
          write_reg(tpsg_pkg::REG_PI_ONE, 62'(rand64() >> $urandom_range(20, 40)));
          write_reg(tpsg_pkg::REG_GAMMA_TWO, 62'd0);  // gamma below one
          write_reg(tpsg_pkg::REG_PI_TWO, 62'(rand64() >> $urandom_range(2, 60)));
          send_idle = 74; recv_idle = 24;
        end
        default: begin
          write_reg(tpsg_pkg::REG_GAMMA_ONE, 62'(tpsg_pkg::GAMMA_RST));
          write_reg(tpsg_pkg::REG_PI_ONE, 62'd1 << 30);
          write_reg(tpsg_pkg::REG_GAMMA_TWO, 62'($urandom_range(0, (1 << 29) - 1)));
          write_reg(tpsg_pkg::REG_PI_TWO, 62'(rand64() >> 22));
          send_idle = 0; recv_idle = 0;
        end
      endcase

      if (phase == 0) begin
        // directed cells: field extremes, zero density, clamped fraction, saturation
        pending_cells.push_back(make_cell(0, 0, 0, 0, 0, 0, 0, 0));
        pending_cells.push_back(make_cell(25'd1 << 24, 1 << 24, 2 << 24, 10 << 24,
                                          1 << 24, -(3 << 24), 5 << 24, 0));
        pending_cells.push_back(make_cell('1, 1 << 24, 1 << 24, 1 << 24,
                                          1 << 24, 1 << 24, 1 << 24, 1));
        pending_cells.push_back(make_cell(25'd1 << 23, 0, 7 << 24, 9 << 24,
                                          0, -(7 << 24), -(9 << 24), 0));
        pending_cells.push_back(make_cell(25'd1 << 23, rmax, POS_LIMIT, POS_LIMIT,
                                          rmax, NEG_LIMIT, NEG_LIMIT, 0));
        pending_cells.push_back(make_cell(0, 1, POS_LIMIT, NEG_LIMIT,
                                          1, NEG_LIMIT, POS_LIMIT, 0));
        pending_cells.push_back(make_cell(25'd1 << 24, 1, 64'd1 << 40, 64'd1 << 62,
                                          1, -(64'd1 << 39), -(64'd1 << 62), 1));
        pending_cells.push_back(make_cell(25'd12345, 3, NEG_LIMIT, 0,
                                          rmax, 1, -1, 0));
        pending_cells.push_back(make_cell(25'd1 << 22, 0, POS_LIMIT, NEG_LIMIT,
                                          0, NEG_LIMIT, POS_LIMIT, 0));
        pending_cells.push_back(make_cell(25'h1000001, 1 << 20, 64'd1 << 44, -(64'd1 << 50),
                                          1 << 20, -(64'd1 << 44), 64'd1 << 50, 1));
      end
      for (int n = 0; n < 330; n++) pending_cells.push_back(random_cell());

      while (pending_cells.size() != 0 || in_tvalid || flux_expected.size() != 0)
        @(posedge clk);
      repeat (DRAIN_WAIT) @(posedge clk);
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tpsg_pkg.sv
rtl/tpsg_dly.sv
rtl/tpsg_mul.sv
rtl/tpsg_div.sv
rtl/tpsg_lane.sv
rtl/two_phase_stiffened_gas_flux.sv
verif/tb_two_phase_stiffened_gas_flux.sv
